FILE: rtl/bed_pkg.sv
// ----------------------------------------------------------------------------
// bed_pkg
// Shared constants, types and hex-pair helpers for the escape decoder.
// ----------------------------------------------------------------------------
package bed_pkg;

  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_N       = 8'h6E;
  localparam logic [7:0] CH_X       = 8'h78;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam int unsigned HEX_RADIX = 16;

  // Up to three results produced by one input transfer, oldest in slot 0.
  typedef struct packed {
    logic [1:0]       cnt;
    logic [2:0][7:0]  bytes;
    logic             last;   // applies to the final result only
  } bed_bundle_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_sign(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS);
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) r = {1'b1, 4'(c - 8'h30)};
    else if (c inside {[8'h61:8'h66]}) r = {1'b1, 4'(c - 8'h61 + 8'd10)};
    else if (c inside {[8'h41:8'h46]}) r = {1'b1, 4'(c - 8'h41 + 8'd10)};
    return r;
  endfunction

  // strtol base 16 over a two-byte window, kept to 8 bits.
  function automatic logic [7:0] pair_value(input logic [7:0] first,
                                            input logic [7:0] second);
    logic [4:0] h1;
    logic [4:0] h2;
    logic [7:0] acc;
    h1  = hex_digit(first);
    h2  = hex_digit(second);
    acc = 8'd0;
    if (is_space(first)) begin
      if (!is_sign(second) && h2[4]) acc = {4'd0, h2[3:0]};
    end else if (is_sign(first)) begin
      if (h2[4]) acc = {4'd0, h2[3:0]};
      if (first == CH_MINUS) acc = 8'd0 - acc;
    end else if (h1[4]) begin
      if (h2[4]) acc = 8'(h1[3:0] * HEX_RADIX) + {4'd0, h2[3:0]};
      else       acc = {4'd0, h1[3:0]};
    end
    return acc;
  endfunction

endpackage

FILE: rtl/bed_ifs.sv
// ----------------------------------------------------------------------------
// bed_ifs
// Valid/ready stream interfaces for raw and unescaped bytes.
// ----------------------------------------------------------------------------
interface bed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_last;

  modport source (output valid, output in_byte, output is_last, input ready);
  modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

interface bed_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

FILE: rtl/backslash_escape_decoder_unit.sv
// ----------------------------------------------------------------------------
// backslash_escape_decoder_unit
// Path: an input transfer loads the bundle register, which in turn loads the
//   output register that drives out valid.
// Throughput: one input byte per cycle while each byte yields at most one
//   result and the output is not stalled; a byte yielding 2 or 3 results holds
//   input off while the output register drains the result bundle.
// Reset: synchronous active-low rst_n clears escape phase, held pair byte and
//   all valid flags.
// ----------------------------------------------------------------------------
module backslash_escape_decoder_unit (
  input  logic           clk,
  input  logic           rst_n,
  bed_in_if.sink         in_ch,
  bed_out_if.source      out_ch
);

  // Decoder output for the byte currently offered on the input channel.
  // It is only committed (state update, bundle load) on a transfer.
  bed_pkg::bed_bundle_t bundle;
  logic                 in_xfer;

  assign in_xfer = in_ch.valid && in_ch.ready;

  // Escape phase and held pair byte live here; combinational decode of
  // one byte into up to three result bytes.
  bed_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_xfer),
    .in_byte (in_ch.in_byte),
    .is_last (in_ch.is_last),
    .bundle  (bundle)
  );

  // Bundle register plus output register. Input is taken whenever the
  // bundle is empty or is handing off its final byte this cycle, so a
  // stalled output byte does not block an input transfer into an empty bundle.
  bed_drain u_drain (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .bundle    (bundle),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte),
    .out_last  (out_ch.out_last)
  );

endmodule

FILE: rtl/bed_decode.sv
// ----------------------------------------------------------------------------
// bed_decode
// Escape state machine: maps one raw byte to a bundle of 0..3 results.
// ----------------------------------------------------------------------------
module bed_decode (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [7:0]           in_byte,
  input  logic                 is_last,
  output bed_pkg::bed_bundle_t bundle
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_ESC  = 2'd1;
  localparam logic [1:0] PH_X    = 2'd2;
  localparam logic [1:0] PH_X1   = 2'd3;

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;

  always_comb begin
    phase_nxt    = phase_r;
    held_nxt     = held_r;
    bundle.cnt   = 2'd0;
    bundle.bytes = '0;
    bundle.last  = is_last;
    case (phase_r)
      PH_IDLE: begin
        if (in_byte == bed_pkg::CH_BSLASH && !is_last) begin
          phase_nxt = PH_ESC;
        end else begin
          bundle.cnt      = 2'd1;
          bundle.bytes[0] = in_byte;
        end
      end
      PH_ESC: begin
        phase_nxt = PH_IDLE;
        if (in_byte == bed_pkg::CH_N) begin
          bundle.cnt      = 2'd1;
          bundle.bytes[0] = bed_pkg::CH_NEWLINE;
        end else if (in_byte == bed_pkg::CH_BSLASH) begin
          bundle.cnt      = 2'd1;
          bundle.bytes[0] = bed_pkg::CH_BSLASH;
        end else if (in_byte == bed_pkg::CH_X && !is_last) begin
          phase_nxt = PH_X;
        end else begin
          bundle.cnt      = 2'd2;
          bundle.bytes[0] = bed_pkg::CH_BSLASH;
          bundle.bytes[1] = in_byte;
        end
      end
      PH_X: begin
        if (is_last) begin
          // cut-off escape, replay everything literally
          phase_nxt       = PH_IDLE;
          bundle.cnt      = 2'd3;
          bundle.bytes[0] = bed_pkg::CH_BSLASH;
          bundle.bytes[1] = bed_pkg::CH_X;
          bundle.bytes[2] = in_byte;
        end else begin
          held_nxt  = in_byte;
          phase_nxt = PH_X1;
        end
      end
      PH_X1: begin
        phase_nxt       = PH_IDLE;
        bundle.cnt      = 2'd1;
        bundle.bytes[0] = bed_pkg::pair_value(held_r, in_byte);
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      held_r  <= 8'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

FILE: rtl/bed_drain.sv
// ----------------------------------------------------------------------------
// bed_drain
// Holds a result bundle and feeds it one byte per transfer to the output reg.
// ----------------------------------------------------------------------------
module bed_drain (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bed_pkg::bed_bundle_t bundle,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic                 out_last
);

  logic [1:0]      cnt_r, cnt_nxt;
  logic [2:0][7:0] bytes_r, bytes_nxt;
  logic            last_r, last_nxt;
  logic            ovalid_r;
  logic [7:0]      obyte_r;
  logic            olast_r;
  logic            out_load;
  logic            in_xfer;

  assign out_load = (cnt_r != 2'd0) && (!ovalid_r || out_ready);
  assign in_ready = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_load);
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    cnt_nxt   = cnt_r;
    bytes_nxt = bytes_r;
    last_nxt  = last_r;
    if (in_xfer) begin
      cnt_nxt   = bundle.cnt;
      bytes_nxt = bundle.bytes;
      last_nxt  = bundle.last;
    end else if (out_load) begin
      cnt_nxt   = cnt_r - 2'd1;
      bytes_nxt = {8'd0, bytes_r[2], bytes_r[1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      ovalid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (out_load) begin
        ovalid_r <= 1'b1;
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
    last_r  <= last_nxt;
    if (out_load) begin
      obyte_r <= bytes_r[0];
      olast_r <= last_r && (cnt_r == 2'd1);
    end
  end

  assign out_valid = ovalid_r;
  assign out_byte  = obyte_r;
  assign out_last  = olast_r;

endmodule

FILE: rtl/bed_checker.sv
// ----------------------------------------------------------------------------
// bed_checker
// Port-level assertions for the escape decoder, bound to the top level.
// ----------------------------------------------------------------------------
module bed_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready
);

  // Output must hold until transferred.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out valid dropped without transfer");

  // Input is held off only while an output byte is pending, or just after
  // a multi-result bundle was loaded.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid || $past(in_valid && in_ready))
    else $error("input stalled with no pending output");

  // A stalled output with bundle empty must still leave input open:
  // right after an input stall with no byte shown, a byte must be showing.
  a_stall_progress: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready && !out_valid |=> out_valid)
    else $error("stall without output progress");

endmodule

bind backslash_escape_decoder_unit bed_checker u_bed_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for backslash_escape_decoder_unit. Raw strings go in
// through the input stream with random gaps. A local unescape predictor turns
// every accepted byte into the bytes that should come out. The result stream
// is stalled at random, and every result is compared in order against that
// prediction.
// ----------------------------------------------------------------------------
module tb;

  // Predictor escape state, mirrors what the decoder has to track.
  typedef enum logic [1:0] {
    ESC_IDLE,   // no escape pending
    ESC_SEEN,   // backslash taken
    ESC_HEX,    // backslash-x taken
    ESC_HEX1    // backslash-x and first pair byte taken
  } esc_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } unesc_t;

  typedef logic [7:0] byte_q_t[$];

  localparam int MAX_SHOWN = 10;
  localparam int IDLE_PCT  = 31;

  // Bytes that steer the hex pair parser one way or the other.
  localparam string HEX_CHARS  = "0123456789abcdefABCDEF";
  localparam string NEAR_HEX   = "/:@G`g";
  localparam logic [7:0] CH_D0 = 8'h30;
  localparam logic [7:0] CH_D9 = 8'h39;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LF = 8'h66;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UF = 8'h46;

  logic clk;
  logic rst_n;

  bed_in_if  in_if ();
  bed_out_if out_if ();

  backslash_escape_decoder_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // Predictor state and the bytes still owed by the decoder, oldest first.
  esc_phase_t phase_q;
  logic [7:0] held_q;
  unesc_t     unescaped_q[$];

  int err_count;
  int items_sent;
  bit idling_on;   // cleared for the back-to-back stretch

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop, reported as errors.
  initial begin
    #2ms;
    $display("tb: errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Unescape predictor
  // --------------------------------------------------------------------------

  // Hex digit value, -1 for anything that is not a hex digit.
  function automatic int nibble_of(input logic [7:0] c);
    if (c >= CH_D0 && c <= CH_D9) return int'(c - CH_D0);
    if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
    if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
    return -1;
  endfunction

  // strtol base 16 over a two byte window: one leading whitespace byte,
  // optional sign, then digits until the first non-hex byte.
  function automatic logic [7:0] hex_pair(input logic [7:0] first,
                                          input logic [7:0] second);
    logic [7:0] seq [2];
    int         pos;
    int         acc;
    int         d;
    bit         neg;
    seq[0] = first;
    seq[1] = second;
    pos    = 0;
    acc    = 0;
    neg    = 1'b0;
    // tab, LF, VT, FF and CR sit in one contiguous range
    if (first == bed_pkg::CH_SPACE ||
        (first >= bed_pkg::CH_TAB && first <= bed_pkg::CH_CR)) pos = 1;
    if (pos < 2 && (seq[pos] == bed_pkg::CH_MINUS || seq[pos] == bed_pkg::CH_PLUS)) begin
      neg = (seq[pos] == bed_pkg::CH_MINUS);
      pos++;
    end
    while (pos < 2) begin
      d = nibble_of(seq[pos]);
      if (d < 0) break;
      acc = acc * bed_pkg::HEX_RADIX + d;
      pos++;
    end
    if (neg) acc = 256 - acc;
    return acc[7:0];
  endfunction

  // Advance the predictor by one accepted raw byte and queue what it yields.
  function automatic void predict_unescape(input logic [7:0] b, input logic last);
    case (phase_q)
      ESC_IDLE: begin
        if (b == bed_pkg::CH_BSLASH && !last) phase_q = ESC_SEEN;
        else unescaped_q.push_back('{b, last});
      end
      ESC_SEEN: begin
        phase_q = ESC_IDLE;
        if (b == bed_pkg::CH_N) begin
          unescaped_q.push_back('{bed_pkg::CH_NEWLINE, last});
        end else if (b == bed_pkg::CH_BSLASH) begin
          unescaped_q.push_back('{bed_pkg::CH_BSLASH, last});
        end else if (b == bed_pkg::CH_X && !last) begin
          phase_q = ESC_HEX;
        end else begin
          // unknown escape, or backslash-x cut by the last byte
          unescaped_q.push_back('{bed_pkg::CH_BSLASH, 1'b0});
          unescaped_q.push_back('{b, last});
        end
      end
      ESC_HEX: begin
        if (last) begin
          // pair cut short: flush everything held literally
          unescaped_q.push_back('{bed_pkg::CH_BSLASH, 1'b0});
          unescaped_q.push_back('{bed_pkg::CH_X, 1'b0});
          unescaped_q.push_back('{b, 1'b1});
          phase_q = ESC_IDLE;
        end else begin
          held_q  = b;
          phase_q = ESC_HEX1;
        end
      end
      default: begin
        unescaped_q.push_back('{hex_pair(held_q, b), last});
        phase_q = ESC_IDLE;
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // One input transfer. valid stays high between back-to-back bytes and is
  // only dropped for a gap, so it never sees two updates in one step.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (idling_on && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    in_if.is_last <= last;
    do @(posedge clk); while (!in_if.ready);
    predict_unescape(b, last);
    items_sent++;
  endtask

  task automatic send_string(input byte_q_t s);
    foreach (s[i]) send_byte(s[i], i == s.size() - 1);
  endtask

  // Pair bytes biased toward what the hex parser cares about.
  function automatic logic [7:0] pair_byte_pick();
    case ($urandom_range(5))
      0:       return HEX_CHARS[$urandom_range(HEX_CHARS.len() - 1)];
      1:       return ($urandom_range(5) == 0) ? bed_pkg::CH_SPACE
                                               : 8'($urandom_range(13, 9));
      2:       return $urandom_range(1) ? bed_pkg::CH_PLUS : bed_pkg::CH_MINUS;
      3:       return 8'h00;
      4:       return NEAR_HEX[$urandom_range(NEAR_HEX.len() - 1)];
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Mostly well-formed escapes with random content, some noise, and now and
  // then a string chopped so its last byte may land inside an escape.
  function automatic byte_q_t random_string();
    byte_q_t s;
    int      n_tok;
    n_tok = $urandom_range(1, 4);
    for (int t = 0; t < n_tok; t++) begin
      case ($urandom_range(9))
        0, 1: s.push_back(8'($urandom_range(255)));
        2: begin
          s.push_back(bed_pkg::CH_BSLASH);
          s.push_back(bed_pkg::CH_N);
        end
        3: begin
          s.push_back(bed_pkg::CH_BSLASH);
          s.push_back(bed_pkg::CH_BSLASH);
        end
        4, 5, 6: begin
          s.push_back(bed_pkg::CH_BSLASH);
          s.push_back(bed_pkg::CH_X);
          s.push_back(pair_byte_pick());
          s.push_back(pair_byte_pick());
        end
        7: begin
          s.push_back(bed_pkg::CH_BSLASH);
          s.push_back(8'($urandom_range(255)));
        end
        default: begin
          s.push_back($urandom_range(1) ? bed_pkg::CH_BSLASH : bed_pkg::CH_X);
          s.push_back(pair_byte_pick());
        end
      endcase
    end
    if (s.size() > 1 && $urandom_range(3) == 0)
      repeat ($urandom_range(1, s.size() - 1)) void'(s.pop_back());
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Newline, doubled backslash, unknown escape, lone trailing backslash and
  // the byte extremes as plain text.
  task automatic test_simple_escapes();
    send_string('{bed_pkg::CH_BSLASH, bed_pkg::CH_N});
    send_string('{bed_pkg::CH_BSLASH, bed_pkg::CH_BSLASH});
    send_string('{bed_pkg::CH_BSLASH, 8'h00});
    send_string('{bed_pkg::CH_BSLASH});
    send_string('{8'h00, 8'hFF});
  endtask

  // Plain pair, negated digit, leading whitespace.
  task automatic test_hex_pairs();
    send_string('{bed_pkg::CH_BSLASH, bed_pkg::CH_X, "4", "F"});
    send_string('{bed_pkg::CH_BSLASH, bed_pkg::CH_X, "-", "1"});
    send_string('{bed_pkg::CH_BSLASH, bed_pkg::CH_X, " ", "7"});
  endtask

  // Escapes ended by the last byte come out literally, mark on the final one.
  task automatic test_cut_escapes();
    send_string('{bed_pkg::CH_BSLASH, bed_pkg::CH_X});
    send_string('{bed_pkg::CH_BSLASH, bed_pkg::CH_X, "A"});
  endtask

  task automatic test_random_strings(input int n_items, input bit with_idling);
    int goal;
    idling_on = with_idling;
    goal      = items_sent + n_items;
    while (items_sent < goal) send_string(random_string());
    idling_on = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Result side: random back-pressure and in-order checking
  // --------------------------------------------------------------------------

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_if.ready <= !idling_on || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    unesc_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (unescaped_q.size() == 0) begin
        err_count++;
        if (err_count <= MAX_SHOWN)
          $display("%0t unexpected transfer: byte %02h last %0b",
                   $realtime, out_if.out_byte, out_if.out_last);
      end else begin
        want = unescaped_q.pop_front();
        if (out_if.out_byte !== want.data || out_if.out_last !== want.last) begin
          err_count++;
          if (err_count <= MAX_SHOWN)
            $display("%0t mismatch: byte exp %02h got %02h, last exp %0b got %0b",
                     $realtime, want.data, out_if.out_byte, want.last, out_if.out_last);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    rst_n         <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.in_byte <= 8'h00;
    in_if.is_last <= 1'b0;
    err_count  = 0;
    items_sent = 0;
    idling_on  = 1'b1;
    phase_q    = ESC_IDLE;
    held_q     = 8'h00;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_simple_escapes();
    test_hex_pairs();
    test_cut_escapes();
    test_random_strings(30, 1'b1);
    test_random_strings(25, 1'b0);   // no gaps, no stalls
    test_random_strings(25, 1'b1);
    in_if.valid <= 1'b0;

    // drain, then give stray results time to show up
    while (unescaped_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (err_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/bed_pkg.sv
rtl/bed_ifs.sv
rtl/bed_decode.sv
rtl/bed_drain.sv
rtl/backslash_escape_decoder_unit.sv
rtl/bed_checker.sv
tb/tb.sv
